// ----- rtl/core/assert_macros.svh -----
// assertion helpers, clocked on i_clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/clcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package clcd_pkg;

    localparam int unsigned TIMER_WIDTH_DEF = 16;
    localparam int unsigned ADDR_W          = 5;
    localparam int unsigned DATA_W          = 32;

    localparam logic [15:0] POWER_ON_RESET  = 16'd50000;
    localparam logic [15:0] INIT_GAP_RESET  = 16'd5000;
    localparam logic [15:0] CMD_WAIT_RESET  = 16'd2000;
    localparam logic [15:0] NIB_GAP_RESET   = 16'd100;
    localparam logic [7:0]  EN_PULSE_RESET  = 8'd1;

    localparam logic [7:0] NIB_WAKE = 8'h03;
    localparam logic [7:0] NIB_FUNC = 8'h02;
    localparam logic [7:0] NIB_MASK = 8'h0F;

    localparam logic [3:0] STEP_WAKE_END = 4'd3;
    localparam logic [3:0] STEP_FUNC     = 4'd3;
    localparam logic [3:0] STEP_CMD_BEG  = 4'd4;
    localparam logic [3:0] INIT_DONE     = 4'd8;

    typedef enum logic [2:0] {
        REG_POWER_ON  = 3'd0,
        REG_INIT_GAP  = 3'd1,
        REG_CMD_WAIT  = 3'd2,
        REG_NIB_GAP   = 3'd3,
        REG_EN_PULSE  = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_POWER   = 3'd0,
        PH_ENABLE  = 3'd1,
        PH_GAP     = 3'd2,
        PH_INITGAP = 3'd3,
        PH_CMDWAIT = 3'd4,
        PH_IDLE    = 3'd5
    } t_phase;

    typedef struct packed {
        logic [15:0] power_on_wait_us;
        logic [15:0] init_gap_us;
        logic [15:0] command_wait_us;
        logic [15:0] nibble_gap_us;
        logic [7:0]  enable_pulse_us;
    } t_cfg;

    typedef struct packed {
        logic       tick;
        logic       req_valid;
        logic [7:0] byte_value;
        logic       func;
    } t_req;

    typedef struct packed {
        logic       pin_rs;
        logic       pin_en;
        logic [3:0] pin_data;
        logic       ready_res;
        logic       dropped;
    } t_res;

    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] cmd;
        case (idx)
            2'd0:    cmd = 8'h28;
            2'd1:    cmd = 8'h0C;
            2'd2:    cmd = 8'h06;
            default: cmd = 8'h01;
        endcase
        return cmd;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/clcd_chan_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface clcd_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/clcd_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
module clcd_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [clcd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [clcd_pkg::DATA_W-1:0] pwdata,
    output logic      [clcd_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output clcd_pkg::t_cfg                   o_cfg
);

    clcd_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[clcd_pkg::ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_on_wait_us <= clcd_pkg::POWER_ON_RESET;
            r_cfg.init_gap_us      <= clcd_pkg::INIT_GAP_RESET;
            r_cfg.command_wait_us  <= clcd_pkg::CMD_WAIT_RESET;
            r_cfg.nibble_gap_us    <= clcd_pkg::NIB_GAP_RESET;
            r_cfg.enable_pulse_us  <= clcd_pkg::EN_PULSE_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                clcd_pkg::REG_POWER_ON: r_cfg.power_on_wait_us <= pwdata[15:0];
                clcd_pkg::REG_INIT_GAP: r_cfg.init_gap_us      <= pwdata[15:0];
                clcd_pkg::REG_CMD_WAIT: r_cfg.command_wait_us  <= pwdata[15:0];
                clcd_pkg::REG_NIB_GAP:  r_cfg.nibble_gap_us    <= pwdata[15:0];
                clcd_pkg::REG_EN_PULSE: r_cfg.enable_pulse_us  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            clcd_pkg::REG_POWER_ON: prdata = 32'(r_cfg.power_on_wait_us);
            clcd_pkg::REG_INIT_GAP: prdata = 32'(r_cfg.init_gap_us);
            clcd_pkg::REG_CMD_WAIT: prdata = 32'(r_cfg.command_wait_us);
            clcd_pkg::REG_NIB_GAP:  prdata = 32'(r_cfg.nibble_gap_us);
            clcd_pkg::REG_EN_PULSE: prdata = 32'(r_cfg.enable_pulse_us);
            default:                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/clcd_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module clcd_seq #(
    parameter int unsigned TIMER_WIDTH = clcd_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire clcd_pkg::t_cfg  i_cfg,
    clcd_chan_if.sink            i_req,
    clcd_chan_if.source          o_res
);

    function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [15:0] v);
        if ((32'(v) >> TIMER_WIDTH) != 32'd0) begin
            return '1;
        end
        return TIMER_WIDTH'(v);
    endfunction

    logic                      r_in_valid;
    clcd_pkg::t_req            r_in;
    logic                      r_out_valid;
    clcd_pkg::t_res            r_out;

    clcd_pkg::t_phase          r_phase,     n_phase;
    logic [TIMER_WIDTH-1:0]    r_wait,      n_wait;
    logic [3:0]                r_init_step, n_init_step;
    logic [7:0]                r_held_byte, n_held_byte;
    logic                      r_held_sel,  n_held_sel;
    logic                      r_low_next,  n_low_next;
    logic                      r_pin_rs,    n_pin_rs;
    logic                      r_pin_en,    n_pin_en;
    logic [3:0]                r_pin_data,  n_pin_data;
    logic                      n_drop;
    clcd_pkg::t_res            n_res;

    logic                      adv;
    logic                      do_finish;
    logic                      do_disp;
    logic [3:0]                disp_step;
    logic                      do_nib;
    logic [3:0]                nib;
    logic [7:0]                cmd_byte;

    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || adv;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // next state for one beat
    always_comb begin
        n_phase     = r_phase;
        n_wait      = r_wait;
        n_init_step = r_init_step;
        n_held_byte = r_held_byte;
        n_held_sel  = r_held_sel;
        n_low_next  = r_low_next;
        n_pin_rs    = r_pin_rs;
        n_pin_en    = r_pin_en;
        n_pin_data  = r_pin_data;
        n_drop      = 1'b0;
        do_finish   = 1'b0;
        do_disp     = 1'b0;
        disp_step   = r_init_step;
        do_nib      = 1'b0;
        nib         = '0;
        cmd_byte    = '0;

        if (r_phase == clcd_pkg::PH_IDLE) begin
            if (r_in.req_valid) begin
                n_held_byte = r_in.byte_value;
                n_held_sel  = r_in.func;
                n_low_next  = 1'b0;
                n_pin_rs    = r_in.func;
                do_nib      = 1'b1;
                nib         = r_in.byte_value[7:4];
            end
        end else begin
            n_drop = r_in.req_valid;
            if (r_in.tick) begin
                if (r_wait > TIMER_WIDTH'(1)) begin
                    n_wait = r_wait - TIMER_WIDTH'(1);
                end else begin
                    case (r_phase)
                        clcd_pkg::PH_POWER: begin
                            n_init_step = '0;
                            do_disp     = 1'b1;
                            disp_step   = '0;
                        end
                        clcd_pkg::PH_ENABLE: begin
                            n_pin_en = 1'b0;
                            n_phase  = clcd_pkg::PH_GAP;
                            n_wait   = sat_load(i_cfg.nibble_gap_us);
                        end
                        clcd_pkg::PH_GAP: begin
                            if (r_init_step < clcd_pkg::STEP_CMD_BEG) begin
                                if (r_init_step < clcd_pkg::STEP_WAKE_END) begin
                                    n_phase = clcd_pkg::PH_INITGAP;
                                    n_wait  = sat_load(i_cfg.init_gap_us);
                                end else begin
                                    do_finish = 1'b1;
                                end
                            end else if (!r_low_next) begin
                                n_low_next = 1'b1;
                                do_nib     = 1'b1;
                                nib        = 4'(r_held_byte & clcd_pkg::NIB_MASK);
                            end else if (!r_held_sel) begin
                                n_phase = clcd_pkg::PH_CMDWAIT;
                                n_wait  = sat_load(i_cfg.command_wait_us);
                            end else begin
                                do_finish = 1'b1;
                            end
                        end
                        clcd_pkg::PH_INITGAP,
                        clcd_pkg::PH_CMDWAIT: begin
                            do_finish = 1'b1;
                        end
                        default: begin
                            n_phase = clcd_pkg::PH_IDLE;
                            n_wait  = '0;
                        end
                    endcase
                end
            end
        end

        if (do_finish) begin
            if (r_init_step < clcd_pkg::INIT_DONE) begin
                n_init_step = r_init_step + 4'd1;
                do_disp     = 1'b1;
                disp_step   = r_init_step + 4'd1;
            end else begin
                n_phase = clcd_pkg::PH_IDLE;
                n_wait  = '0;
            end
        end

        if (do_disp) begin
            cmd_byte = clcd_pkg::init_cmd(disp_step[1:0]);
            if (disp_step < clcd_pkg::STEP_WAKE_END) begin
                n_held_byte = clcd_pkg::NIB_WAKE;
                n_held_sel  = 1'b0;
                n_pin_rs    = 1'b0;
                do_nib      = 1'b1;
                nib         = clcd_pkg::NIB_WAKE[3:0];
            end else if (disp_step == clcd_pkg::STEP_FUNC) begin
                n_held_byte = clcd_pkg::NIB_FUNC;
                n_held_sel  = 1'b0;
                n_pin_rs    = 1'b0;
                do_nib      = 1'b1;
                nib         = clcd_pkg::NIB_FUNC[3:0];
            end else if (disp_step < clcd_pkg::INIT_DONE) begin
                n_held_byte = cmd_byte;
                n_held_sel  = 1'b0;
                n_low_next  = 1'b0;
                n_pin_rs    = 1'b0;
                do_nib      = 1'b1;
                nib         = cmd_byte[7:4];
            end else begin
                n_phase = clcd_pkg::PH_IDLE;
                n_wait  = '0;
            end
        end

        if (do_nib) begin
            n_pin_data = nib;
            n_pin_en   = 1'b1;
            n_phase    = clcd_pkg::PH_ENABLE;
            n_wait     = sat_load(16'(i_cfg.enable_pulse_us));
        end
    end

    // result beat
    always_comb begin
        n_res.pin_rs    = n_pin_rs;
        n_res.pin_en    = n_pin_en;
        n_res.pin_data  = n_pin_data;
        n_res.ready_res = (n_phase == clcd_pkg::PH_IDLE);
        n_res.dropped   = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= clcd_pkg::PH_POWER;
            r_wait      <= sat_load(clcd_pkg::POWER_ON_RESET);
            r_init_step <= '0;
            r_held_byte <= '0;
            r_held_sel  <= 1'b0;
            r_low_next  <= 1'b0;
            r_pin_rs    <= 1'b0;
            r_pin_en    <= 1'b0;
            r_pin_data  <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                r_phase     <= n_phase;
                r_wait      <= n_wait;
                r_init_step <= n_init_step;
                r_held_byte <= n_held_byte;
                r_held_sel  <= n_held_sel;
                r_low_next  <= n_low_next;
                r_pin_rs    <= n_pin_rs;
                r_pin_en    <= n_pin_en;
                r_pin_data  <= n_pin_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.payload;
        end
        if (adv) begin
            r_out <= n_res;
        end
    end

    `ASSERT_NEXT(a_adv_loads_out, adv, r_out_valid, "step beat did not reach result register")
    `ASSERT_ALWAYS(a_en_in_enable, r_pin_en == (r_phase == clcd_pkg::PH_ENABLE), "bad enable")
    `ASSERT_ALWAYS(a_step_range, r_init_step <= clcd_pkg::INIT_DONE, "init step past done")
    `ASSERT_IMPL(a_idle_timer_clear, r_phase == clcd_pkg::PH_IDLE, r_wait == '0, "idle timer set")

endmodule
`default_nettype wire

// ----- rtl/core/char_lcd_4bit_interface.sv -----
`timescale 1ns / 1ps
`default_nettype none
// flow: a request beat lands in the input register; its result beat is then
// registered in the output register once the output is not stalled
// throughput: one beat per clock unless o_res stalls, set by the step logic
// reset: synchronous active low; control registers take reset values, the
// pin registers go low and the power-on countdown starts from POWER_ON_RESET
module char_lcd_4bit_interface #(
    parameter int unsigned TIMER_WIDTH = clcd_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [clcd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [clcd_pkg::DATA_W-1:0] pwdata,
    output logic      [clcd_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    clcd_chan_if.sink                        i_req,
    clcd_chan_if.source                      o_res
);

    clcd_pkg::t_cfg cfg;

    clcd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    clcd_seq #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire
